// ----- src/acsp_pkg.sv -----
package acsp_pkg;

  localparam int unsigned SAMPLE_RATE_DEF = 1;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned COUNT_W = 24;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_NO_DELIM = 2'd0;
  localparam logic [1:0] ERR_NO_DIGITS = 2'd1;
  localparam logic [1:0] ERR_ZERO_PERIOD = 2'd2;

  localparam logic [1:0] REG_DELIM = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  localparam logic [7:0] CHAR_NL = 8'd10;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;
  localparam logic [7:0] CHAR_PLUS = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_CR = 8'd13;

  localparam logic [16:0] MAG_MAX = 17'd32768;

  typedef enum logic [2:0] {
    PH_START,
    PH_DIV,
    PH_HEADER,
    PH_SKIP,
    PH_STAMP,
    PH_FIELD,
    PH_HALT
  } acsp_phase_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [1:0]         code;
    logic [COUNT_W-1:0] lines;
    logic               last;
  } acsp_result_t;

  typedef struct packed {
    logic         push;
    acsp_result_t res;
  } acsp_push_t;

endpackage

// ----- src/acsp_ifs.sv -----
interface acsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_file;
  modport source (output valid, text_byte, end_of_file, input ready);
  modport sink (input valid, text_byte, end_of_file, output ready);
endinterface

interface acsp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [1:0]         error_code;
  logic [23:0]        lines_parsed;
  logic               last_of_run;
  modport source (output valid, result_kind, accel_x, accel_y, accel_z, error_code,
                  lines_parsed, last_of_run, input ready);
  modport sink (input valid, result_kind, accel_x, accel_y, accel_z, error_code,
                lines_parsed, last_of_run, output ready);
endinterface

interface acsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/accel_csv_sample_parser_core.sv -----
// Accelerometer CSV sample parser.
// in_if carries one file byte per request with an end-of-file flag; out_if
// returns results (sample, end-of-file summary, error); cfg_if writes the
// delimiter, period and start offset registers, always ready.
// When the period is nonzero, the first byte of a file is held while a
// bit-serial divider computes the skip line count, then it is processed.
// Every other byte is handled as it is taken. A byte that gives both a
// result and a summary pushes the result and holds the summary in a pending
// register, taking no new byte until it is pushed. Results show on out_if
// from the head of a QUEUE_DEPTH entry queue; bytes keep being taken while it
// has room, so a stalled receiver only stops input once the queue fills.
// Reset clears parser state and the queue and sets delimiter to ',',
// period to 1 and offset to 0.
module accel_csv_sample_parser_core import acsp_pkg::*; #(
  parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  acsp_in_if.sink     in_if,
  acsp_out_if.source  out_if,
  acsp_cfg_if.sink    cfg_if
);

  logic [7:0]          delim_q, period_q;
  logic [OFFSET_W-1:0] offset_q;
  logic                full;
  acsp_push_t          push;
  acsp_result_t        res;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q  <= 8'd44;
      period_q <= 8'd1;
      offset_q <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_DELIM:  delim_q  <= cfg_if.data[7:0];
        REG_PERIOD: period_q <= cfg_if.data[7:0];
        REG_OFFSET: offset_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  acsp_front #(.SAMPLE_RATE(SAMPLE_RATE)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_ready_o    (in_if.ready),
    .text_byte_i   (in_if.text_byte),
    .end_of_file_i (in_if.end_of_file),
    .delim_i       (delim_q),
    .period_i      (period_q),
    .offset_i      (offset_q),
    .full_i        (full),
    .push_o        (push)
  );

  acsp_back #(.DEPTH(QUEUE_DEPTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .valid_o (out_if.valid),
    .ready_i (out_if.ready),
    .res_o   (res)
  );

  assign out_if.result_kind  = res.kind;
  assign out_if.accel_x      = res.x;
  assign out_if.accel_y      = res.y;
  assign out_if.accel_z      = res.z;
  assign out_if.error_code   = res.code;
  assign out_if.lines_parsed = res.lines;
  assign out_if.last_of_run  = res.last;

endmodule

// ----- src/acsp_div.sv -----
module acsp_div #(
  parameter int unsigned DW = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [7:0]    divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] sh_q, sh_d;
  logic [7:0]    rem_q, rem_d;
  logic [7:0]    dvs_q, dvs_d;
  logic [8:0]    trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, sh_q[DW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      sh_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 8'(trial - {1'b0, dvs_q});
        sh_d  = {sh_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        sh_d  = {sh_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = sh_q;

endmodule

// ----- src/acsp_front.sv -----
module acsp_front import acsp_pkg::*; #(
  parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          text_byte_i,
  input  logic                end_of_file_i,
  input  logic [7:0]          delim_i,
  input  logic [7:0]          period_i,
  input  logic [OFFSET_W-1:0] offset_i,
  input  logic                full_i,
  output acsp_push_t          push_o
);

  localparam int unsigned RW = $clog2(SAMPLE_RATE + 1);
  localparam int unsigned DW = OFFSET_W + RW;

  acsp_phase_e        phase_q, phase_d;
  logic [31:0]        skip_q, skip_d;
  logic [1:0]         fn_q, fn_d;
  logic [16:0]        acc_q, acc_d;
  logic               neg_q, neg_d, sgn_q, sgn_d, dig_q, dig_d, cls_q, cls_d;
  logic [15:0]        hx_q, hx_d, hy_q, hy_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]         hb_q, hb_d;
  logic               he_q, he_d;
  logic               pend_q, pend_d;
  acsp_result_t       pres_q, pres_d;

  logic          div_start, div_busy;
  logic [DW-1:0] div_quot, dividend;
  logic [63:0]   quot64;
  logic [31:0]   div_skip;

  assign dividend = DW'(offset_i) * DW'(SAMPLE_RATE);
  assign quot64   = 64'(div_quot);
  assign div_skip = (|quot64[63:32]) ? 32'hFFFF_FFFF : quot64[31:0];

  acsp_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (period_i),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  function automatic logic [15:0] num_value(logic [16:0] acc, logic neg);
    logic [15:0] v;
    if (neg) v = (acc >= MAG_MAX) ? 16'h8000 : 16'(17'h10000 - acc);
    else v = (acc > 17'd32767) ? 16'h7FFF : acc[15:0];
    return v;
  endfunction

  acsp_phase_e  p;
  logic [7:0]   b;
  logic         eof, go, do_el, r0_v;
  acsp_result_t r0, summ;
  logic [18:0]  t;

  always_comb begin
    phase_d = phase_q; skip_d = skip_q; fn_d = fn_q; acc_d = acc_q;
    neg_d = neg_q; sgn_d = sgn_q; dig_d = dig_q; cls_d = cls_q;
    hx_d = hx_q; hy_d = hy_q; cnt_d = cnt_q; hb_d = hb_q; he_d = he_q;
    pend_d = pend_q; pres_d = pres_q;
    push_o = '0;
    div_start = 1'b0;
    go = 1'b0; do_el = 1'b0; r0_v = 1'b0; r0 = '0; summ = '0; t = '0;
    p = phase_q;
    b = (phase_q == PH_DIV) ? hb_q : text_byte_i;
    eof = (phase_q == PH_DIV) ? he_q : end_of_file_i;
    in_ready_o = !pend_q && !full_i && (phase_q != PH_DIV);

    if (phase_q == PH_DIV) begin
      if (!div_busy && !full_i) begin
        go = 1'b1; p = PH_HEADER; skip_d = div_skip;
      end
    end else if (in_valid_i && in_ready_o) begin
      if (phase_q == PH_START && period_i != 8'd0) begin
        div_start = 1'b1; phase_d = PH_DIV; hb_d = text_byte_i; he_d = end_of_file_i;
      end else begin
        go = 1'b1;
      end
    end

    if (go) begin
      if (p == PH_START) begin
        r0_v = 1'b1; r0.kind = KIND_ERROR; r0.code = ERR_ZERO_PERIOD; r0.lines = cnt_d;
        p = PH_HALT;
      end
      case (p)
        PH_HEADER: begin
          if (b == CHAR_NL) p = (skip_d != 32'd0) ? PH_SKIP : PH_STAMP;
        end
        PH_SKIP: begin
          if (b == CHAR_NL) begin
            skip_d = skip_d - 32'd1;
            if (skip_d == 32'd0) p = PH_STAMP;
          end
        end
        PH_STAMP: begin
          if (b == CHAR_NL) do_el = 1'b1;
          else if (b == delim_i) begin
            p = PH_FIELD; fn_d = 2'd0;
            acc_d = '0; neg_d = 1'b0; sgn_d = 1'b0; dig_d = 1'b0; cls_d = 1'b0;
          end
        end
        PH_FIELD: begin
          if (b == CHAR_NL) do_el = 1'b1;
          else if (fn_d < 2'd2 && b == delim_i) begin
            if (!dig_d) begin
              r0_v = 1'b1; r0.kind = KIND_ERROR; r0.code = ERR_NO_DIGITS;
              r0.lines = cnt_d; p = PH_HALT;
            end else begin
              if (fn_d == 2'd0) hx_d = num_value(acc_d, neg_d);
              else hy_d = num_value(acc_d, neg_d);
              fn_d = fn_d + 2'd1;
              acc_d = '0; neg_d = 1'b0; sgn_d = 1'b0; dig_d = 1'b0; cls_d = 1'b0;
            end
          end else if (!cls_d) begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
              t = 19'(acc_d) * 19'd10 + 19'(b - CHAR_ZERO);
              acc_d = (t > 19'(MAG_MAX)) ? MAG_MAX : t[16:0];
              dig_d = 1'b1;
            end else if (!dig_d && !sgn_d && (b == CHAR_SPACE ||
                         b inside {[CHAR_TAB:CHAR_CR]})) begin
              acc_d = acc_d;
            end else if (!dig_d && !sgn_d && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
              sgn_d = 1'b1; neg_d = (b == CHAR_MINUS);
            end else begin
              cls_d = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (do_el || (eof && b != CHAR_NL)) begin
        if (p == PH_STAMP || (p == PH_FIELD && fn_d < 2'd2)) begin
          r0_v = 1'b1; r0.kind = KIND_ERROR; r0.code = ERR_NO_DELIM;
          r0.lines = cnt_d; p = PH_HALT;
        end else if (p == PH_FIELD && !dig_d) begin
          r0_v = 1'b1; r0.kind = KIND_ERROR; r0.code = ERR_NO_DIGITS;
          r0.lines = cnt_d; p = PH_HALT;
        end else if (p == PH_FIELD) begin
          if (cnt_d != '1) cnt_d = cnt_d + 1'b1;
          r0_v = 1'b1; r0.kind = KIND_SAMPLE; r0.lines = cnt_d;
          r0.x = hx_d; r0.y = hy_d; r0.z = num_value(acc_d, neg_d);
          p = PH_STAMP; fn_d = 2'd0;
          acc_d = '0; neg_d = 1'b0; sgn_d = 1'b0; dig_d = 1'b0; cls_d = 1'b0;
        end
      end

      phase_d = p;
      if (eof) begin
        summ.kind = KIND_SUMMARY; summ.lines = cnt_d; summ.last = 1'b1;
        if (r0_v) begin
          push_o.push = 1'b1; push_o.res = r0;
          pend_d = 1'b1; pres_d = summ;
        end else begin
          push_o.push = 1'b1; push_o.res = summ;
        end
        phase_d = PH_START; skip_d = '0; fn_d = '0;
        acc_d = '0; neg_d = 1'b0; sgn_d = 1'b0; dig_d = 1'b0; cls_d = 1'b0;
        hx_d = '0; hy_d = '0; cnt_d = '0;
      end else if (r0_v) begin
        r0.last = 1'b1;
        push_o.push = 1'b1; push_o.res = r0;
      end
    end

    if (pend_q && !full_i) begin
      push_o.push = 1'b1; push_o.res = pres_q; pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START; skip_q <= '0; fn_q <= '0; acc_q <= '0;
      neg_q <= 1'b0; sgn_q <= 1'b0; dig_q <= 1'b0; cls_q <= 1'b0;
      hx_q <= '0; hy_q <= '0; cnt_q <= '0; pend_q <= 1'b0;
    end else begin
      phase_q <= phase_d; skip_q <= skip_d; fn_q <= fn_d; acc_q <= acc_d;
      neg_q <= neg_d; sgn_q <= sgn_d; dig_q <= dig_d; cls_q <= cls_d;
      hx_q <= hx_d; hy_q <= hy_d; cnt_q <= cnt_d; pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hb_q <= hb_d; he_q <= he_d; pres_q <= pres_d;
  end

endmodule

// ----- src/acsp_back.sv -----
module acsp_back import acsp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  acsp_push_t   push_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         ready_i,
  output acsp_result_t res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  acsp_result_t  mem_q [DEPTH];
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign res_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i.push) wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    if (pop) rp_d = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    if (push_i.push && !pop) cnt_d = cnt_q + 1'b1;
    else if (!push_i.push && pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) mem_q[wp_q] <= push_i.res;
  end

endmodule

// ----- src/acsp_checker.sv -----
module acsp_checker import acsp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [15:0] ax,
  input logic [15:0] ay,
  input logic [15:0] az,
  input logic        last
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_kind_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(kind)) else $error("result changed");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> kind != 2'd3) else $error("bad kind");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kind == KIND_SUMMARY |-> last) else $error("summary not last");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && kind == KIND_ERROR |-> ax == 16'd0 && ay == 16'd0 && az == 16'd0)
    else $error("error carries data");

endmodule

bind accel_csv_sample_parser_core acsp_checker u_acsp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .kind      (out_if.result_kind),
  .ax        (out_if.accel_x),
  .ay        (out_if.accel_y),
  .az        (out_if.accel_z),
  .last      (out_if.last_of_run)
);

// ----- verif/tb_accel_csv_sample_parser_core.sv -----
`timescale 1ns / 1ps

module tb_accel_csv_sample_parser_core;
  import acsp_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [1:0]  code;
    logic [23:0] lines;
    logic        last;
  } parse_result_t;

  typedef struct {
    logic [7:0]  b;
    logic        eof;
    logic        has_exp;
    parse_result_t exp;
  } byte_row_t;

  logic clk_i;
  logic rst_ni;
  acsp_in_if  in_if ();
  acsp_out_if out_if ();
  acsp_cfg_if cfg_if ();

  accel_csv_sample_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  // parser state mirror
  logic [7:0]  m_delim;
  logic [7:0]  m_period;
  logic [23:0] m_offset;
  acsp_phase_e m_phase;
  logic [31:0] m_skip;
  logic [1:0]  m_field;
  logic [16:0] m_acc;
  logic        m_neg;
  logic        m_sign;
  logic        m_digit;
  logic        m_closed;
  logic [15:0] m_hx;
  logic [15:0] m_hy;
  logic [23:0] m_lines;

  parse_result_t expected_results[$];
  parse_result_t step_out[$];
  int  errors;
  bit  in_idle_en;
  bit  out_idle_en;
  bit  hold_off;
  int  bytes_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic void clear_number();
    m_acc = '0;
    m_neg = 1'b0;
    m_sign = 1'b0;
    m_digit = 1'b0;
    m_closed = 1'b0;
  endfunction

  function automatic void clear_file();
    m_phase = PH_START;
    m_skip = '0;
    m_field = '0;
    clear_number();
    m_hx = '0;
    m_hy = '0;
    m_lines = '0;
  endfunction

  function automatic logic [15:0] number_value();
    if (m_neg) begin
      if (m_acc >= MAG_MAX) return 16'h8000;
      return 16'(17'h10000 - m_acc);
    end
    if (m_acc > 17'd32767) return 16'h7fff;
    return m_acc[15:0];
  endfunction

  function automatic void emit(logic [1:0] kind, logic [15:0] z, logic [1:0] code);
    parse_result_t r;
    r.kind = kind;
    r.x = (kind == KIND_SAMPLE) ? m_hx : '0;
    r.y = (kind == KIND_SAMPLE) ? m_hy : '0;
    r.z = z;
    r.code = code;
    r.lines = m_lines;
    r.last = 1'b0;
    step_out = {step_out, r};
  endfunction

  function automatic void raise_error(logic [1:0] code);
    emit(KIND_ERROR, '0, code);
    m_phase = PH_HALT;
  endfunction

  function automatic void number_byte(logic [7:0] b);
    logic [19:0] t;
    if (m_closed) return;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      t = 20'(m_acc) * 20'd10 + 20'(b - CHAR_ZERO);
      m_acc = (t > 20'(MAG_MAX)) ? MAG_MAX : t[16:0];
      m_digit = 1'b1;
    end else if (!m_digit && !m_sign && (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))) begin
    end else if (!m_digit && !m_sign && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
      m_sign = 1'b1;
      m_neg = (b == CHAR_MINUS);
    end else begin
      m_closed = 1'b1;
    end
  endfunction

  function automatic void end_line();
    if (m_phase == PH_STAMP) begin
      raise_error(ERR_NO_DELIM);
      return;
    end
    if (m_phase != PH_FIELD) return;
    if (m_field < 2) begin
      raise_error(ERR_NO_DELIM);
      return;
    end
    if (!m_digit) begin
      raise_error(ERR_NO_DIGITS);
      return;
    end
    if (m_lines != 24'hffffff) m_lines++;
    emit(KIND_SAMPLE, number_value(), '0);
    m_phase = PH_STAMP;
    m_field = '0;
    clear_number();
  endfunction

  // computes the results of one accepted byte into step_out
  function automatic void parse_byte(logic [7:0] b, logic eof);
    logic [63:0] s;
    step_out.delete();
    if (m_phase == PH_START) begin
      if (m_period == 0) begin
        raise_error(ERR_ZERO_PERIOD);
      end else begin
        s = 64'(m_offset) * 64'(SAMPLE_RATE_DEF) / 64'(m_period);
        m_skip = (s > 64'hffffffff) ? 32'hffffffff : s[31:0];
        m_phase = PH_HEADER;
      end
    end
    case (m_phase)
      PH_HEADER: if (b == CHAR_NL) m_phase = (m_skip != 0) ? PH_SKIP : PH_STAMP;
      PH_SKIP: if (b == CHAR_NL) begin
        m_skip--;
        if (m_skip == 0) m_phase = PH_STAMP;
      end
      PH_STAMP: begin
        if (b == CHAR_NL) end_line();
        else if (b == m_delim) begin
          m_phase = PH_FIELD;
          m_field = '0;
          clear_number();
        end
      end
      PH_FIELD: begin
        if (b == CHAR_NL) end_line();
        else if (m_field < 2 && b == m_delim) begin
          if (!m_digit) raise_error(ERR_NO_DIGITS);
          else begin
            if (m_field == 0) m_hx = number_value();
            else m_hy = number_value();
            m_field++;
            clear_number();
          end
        end else number_byte(b);
      end
      default: ;
    endcase
    if (eof) begin
      if (b != CHAR_NL) end_line();
      emit(KIND_SUMMARY, '0, '0);
      clear_file();
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_DELIM:  m_delim = val[7:0];
      REG_PERIOD: m_period = val[7:0];
      default:    m_offset = val;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // sends one byte; typed expectation overrides the mirror when given
  task automatic send_byte(logic [7:0] b, logic eof, bit has_exp, parse_result_t exp);
    @(negedge clk_i);
    while (in_idle_en && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.text_byte <= b;
    in_if.end_of_file <= eof;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
    parse_byte(b, eof);
    if (has_exp) begin
      if (step_out.size() != 1 || step_out[0] != exp)
        $display("%0t note: typed row differs from model state", $time);
      expected_results = {expected_results, exp};
    end else begin
      foreach (step_out[i]) expected_results = {expected_results, step_out[i]};
    end
  endtask

  task automatic drain();
    int guard;
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    guard = 0;
    while (expected_results.size() > 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= 200000) begin
      $display("Some tests failed");
      $finish;
    end
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_str(string s, logic eof_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eof_last && (i == s.len() - 1), 1'b0, '{default: '0});
  endtask

  function automatic string rand_num();
    string s;
    int n;
    s = "";
    case ($urandom_range(5))
      0: s = " ";
      1: s = "-";
      2: s = "+";
      3: s = "\t-";
      default: ;
    endcase
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) s = {s, string'(8'(CHAR_ZERO + $urandom_range(9)))};
    if ($urandom_range(7) == 0) s = {s, "e"};
    return s;
  endfunction

  task automatic random_file(int nlines);
    string d;
    string l;
    d = string'(m_delim);
    send_str("t,x,y,z\n", 1'b0);
    for (int i = 0; i < nlines; i++) begin
      case ($urandom_range(9))
        0: l = {"1", d, rand_num(), "\n"};
        1: begin
          l = "";
          for (int k = $urandom_range(8, 1); k > 0; k--)
            l = {l, string'(8'($urandom_range(255, 1)))};
        end
        default: l = {string'(8'($urandom_range(255, 11))), d, rand_num(), d, rand_num(),
                      d, rand_num(), "\n"};
      endcase
      send_str(l, 1'b0);
    end
    send_byte(8'($urandom_range(255)), 1'b1, 1'b0, '{default: '0});
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_if.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      out_if.ready <= !(out_idle_en && $urandom_range(99) < 25);
    end
  end

  always @(posedge clk_i) begin
    parse_result_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result kind=%0d", $time, out_if.result_kind);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_if.result_kind !== e.kind || out_if.accel_x !== e.x ||
            out_if.accel_y !== e.y || out_if.accel_z !== e.z ||
            out_if.error_code !== e.code || out_if.lines_parsed !== e.lines ||
            out_if.last_of_run !== e.last) begin
          $display("%0t mismatch exp k=%0d x=%h y=%h z=%h c=%0d n=%0d l=%b", $time,
                   e.kind, e.x, e.y, e.z, e.code, e.lines, e.last);
          $display("%0t          act k=%0d x=%h y=%h z=%h c=%0d n=%0d l=%b", $time,
                   out_if.result_kind, out_if.accel_x, out_if.accel_y, out_if.accel_z,
                   out_if.error_code, out_if.lines_parsed, out_if.last_of_run);
          errors++;
        end
      end
    end
  end

  byte_row_t rows[$];

  function automatic parse_result_t res(logic [1:0] k, logic [1:0] c, logic [23:0] n);
    parse_result_t r;
    r = '{default: '0};
    r.kind = k;
    r.code = c;
    r.lines = n;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void add_row(logic [7:0] b, logic eof, bit he, parse_result_t e);
    byte_row_t r;
    r.b = b; r.eof = eof; r.has_exp = he; r.exp = e;
    rows = {rows, r};
  endfunction

  initial begin
    string s;
    bit held;
    errors = 0;
    bytes_sent = 0;
    held = 1'b0;
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    hold_off = 1'b0;
    in_if.valid = 1'b0;
    in_if.text_byte = '0;
    in_if.end_of_file = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_DELIM;
    cfg_if.data = '0;
    m_delim = 8'd44;
    m_period = 8'd1;
    m_offset = '0;
    clear_file();
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: header, extremes, a no-digits error code
    add_row("h", 1'b0, 0, '{default: '0});
    add_row(CHAR_NL, 1'b0, 0, '{default: '0});
    s = "0,32768,-99999, +12x\n9,-32768,255,-\n";
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 0, '{default: '0});
    add_row(CHAR_NL, 1'b1, 0, '{default: '0});
    add_row(CHAR_NL, 1'b1, 1, res(KIND_SUMMARY, '0, '0));
    foreach (rows[i]) send_byte(rows[i].b, rows[i].eof, rows[i].has_exp, rows[i].exp);
    drain();

    write_reg(REG_PERIOD, 24'd0);
    send_byte("a", 1'b0, 1'b1, res(KIND_ERROR, ERR_ZERO_PERIOD, '0));
    send_byte("b", 1'b1, 1'b1, res(KIND_SUMMARY, '0, '0));
    drain();
    write_reg(REG_PERIOD, 24'd255);
    write_reg(REG_OFFSET, 24'hffffff);
    write_reg(REG_DELIM, 8'd255);
    send_str("h\n1\n", 1'b1);
    drain();
    write_reg(REG_OFFSET, 24'd2);
    write_reg(REG_PERIOD, 24'd1);
    write_reg(REG_DELIM, 8'd59);
    send_str("h\ns\ns\n1;2;3;4\n1;;\n", 1'b1);
    drain();

    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    while (bytes_sent < 800) begin
      case ($urandom_range(3))
        0: write_reg(REG_DELIM, 8'(44));
        1: write_reg(REG_DELIM, 8'($urandom_range(255, 11)));
        default: ;
      endcase
      write_reg(REG_PERIOD, ($urandom_range(15) == 0) ? 24'd0 : 24'($urandom_range(255, 1)));
      write_reg(REG_OFFSET, ($urandom_range(1) == 0) ? 24'd0 : 24'($urandom_range(600)));
      if (!held && bytes_sent > 250) begin
        hold_off = 1'b1;
        held = 1'b1;
      end
      if (bytes_sent > 450 && bytes_sent < 650) begin
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
      end else begin
        in_idle_en = 1'b1;
        out_idle_en = 1'b1;
      end
      random_file($urandom_range(12, 3));
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/acsp_pkg.sv
src/acsp_ifs.sv
src/acsp_div.sv
src/acsp_front.sv
src/acsp_back.sv
src/accel_csv_sample_parser_core.sv
src/acsp_checker.sv
verif/tb_accel_csv_sample_parser_core.sv
